>>> hdl/ltbl_pkg.sv
// Shared types and constants for the line table builder and lookup block.
package ltbl_pkg;

  // Fixed field widths of the channel payloads.
  localparam int CMD_W   = 2;
  localparam int CHAR_W  = 8;
  localparam int FIELD_W = 20;
  localparam int IDX_W   = 11;

  // Largest 20-bit result value; lengths with break saturate to it.
  localparam int FIELD_MAX = 1048575;

  // Input command codes.
  localparam logic [CMD_W-1:0] CMD_BYTE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EOT   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  // Result kinds.
  localparam logic KIND_LINE   = 1'b0;
  localparam logic KIND_ANSWER = 1'b1;

  // Line break characters.
  localparam logic [CHAR_W-1:0] CH_CR = 8'd13;
  localparam logic [CHAR_W-1:0] CH_LF = 8'd10;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EOT2,
    ST_SREAD,
    ST_SCMP,
    ST_QANS
  } state_t;

  // Operations the controller asks of the datapath in one cycle.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_BYTE,
    OP_FLUSH,
    OP_FINAL,
    OP_QSTART,
    OP_QREAD,
    OP_QCMP,
    OP_QANS
  } op_t;

  // Status reported by the datapath to the controller.
  typedef struct packed {
    logic byte_emits;
    logic cr_pending;
    logic text_finished;
    logic search_done;
  } status_t;

endpackage

>>> hdl/ltbl_ctrl.sv
// Controller state machine: input acceptance, operation sequencing and result valid.
module ltbl_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ltbl_pkg::CMD_W-1:0]      in_command,
  output logic                            out_valid,
  input  logic                            out_stall,
  input  ltbl_pkg::status_t               status,
  output ltbl_pkg::op_t                   op
);

  ltbl_pkg::state_t state_r;
  ltbl_pkg::state_t state_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             out_load;
  logic             slot_free;

  // The result register can take a new beat when empty or draining this cycle.
  assign slot_free = !out_valid_r || !out_stall;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ltbl_pkg::ST_IDLE: begin
        if (in_valid && slot_free) begin
          unique case (in_command)
            ltbl_pkg::CMD_EOT: begin
              if (!status.text_finished && status.cr_pending) begin
                state_nxt = ltbl_pkg::ST_EOT2;
              end
            end
            ltbl_pkg::CMD_QUERY: state_nxt = ltbl_pkg::ST_SREAD;
            default:             state_nxt = ltbl_pkg::ST_IDLE;
          endcase
        end
      end
      ltbl_pkg::ST_EOT2: begin
        if (slot_free) begin
          state_nxt = ltbl_pkg::ST_IDLE;
        end
      end
      ltbl_pkg::ST_SREAD: begin
        state_nxt = status.search_done ? ltbl_pkg::ST_QANS : ltbl_pkg::ST_SCMP;
      end
      ltbl_pkg::ST_SCMP: state_nxt = ltbl_pkg::ST_SREAD;
      ltbl_pkg::ST_QANS: begin
        if (slot_free) begin
          state_nxt = ltbl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ltbl_pkg::ST_IDLE;
    endcase
  end

  // Outputs: handshake, datapath operation and result register load.
  always_comb begin
    in_stall = 1'b1;
    op       = ltbl_pkg::OP_NONE;
    out_load = 1'b0;
    unique case (state_r)
      ltbl_pkg::ST_IDLE: begin
        in_stall = !slot_free;
        if (in_valid && slot_free) begin
          unique case (in_command)
            ltbl_pkg::CMD_BYTE: begin
              op       = ltbl_pkg::OP_BYTE;
              out_load = status.byte_emits;
            end
            ltbl_pkg::CMD_EOT: begin
              if (!status.text_finished) begin
                op       = status.cr_pending ? ltbl_pkg::OP_FLUSH : ltbl_pkg::OP_FINAL;
                out_load = 1'b1;
              end
            end
            ltbl_pkg::CMD_QUERY: op = ltbl_pkg::OP_QSTART;
            default:             op = ltbl_pkg::OP_NONE;
          endcase
        end
      end
      ltbl_pkg::ST_EOT2: begin
        if (slot_free) begin
          op       = ltbl_pkg::OP_FINAL;
          out_load = 1'b1;
        end
      end
      ltbl_pkg::ST_SREAD: begin
        if (!status.search_done) begin
          op = ltbl_pkg::OP_QREAD;
        end
      end
      ltbl_pkg::ST_SCMP: op = ltbl_pkg::OP_QCMP;
      ltbl_pkg::ST_QANS: begin
        if (slot_free) begin
          op       = ltbl_pkg::OP_QANS;
          out_load = 1'b1;
        end
      end
      default: op = ltbl_pkg::OP_NONE;
    endcase
  end

  // A loaded beat stays valid until the receiver takes it.
  assign out_valid_nxt = out_load || (out_valid_r && out_stall);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ltbl_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> hdl/ltbl_dpath.sv
// Datapath: text position tracking, line table memory, binary search and result register.
module ltbl_dpath #(
  parameter int MAX_LINES   = 1024,
  parameter int OFFSET_BITS = 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ltbl_pkg::op_t                     op,
  input  logic [ltbl_pkg::CHAR_W-1:0]       in_char_byte,
  input  logic [ltbl_pkg::FIELD_W-1:0]      in_query_offset,
  output ltbl_pkg::status_t                 status,
  output logic                              out_kind,
  output logic [ltbl_pkg::FIELD_W-1:0]      out_line_offset,
  output logic [ltbl_pkg::FIELD_W-1:0]      out_line_length,
  output logic [ltbl_pkg::FIELD_W-1:0]      out_length_with_break,
  output logic [ltbl_pkg::IDX_W-1:0]        out_line_index,
  output logic                              out_overflow,
  output logic                              out_last
);

  localparam int CNT_W  = $clog2(MAX_LINES + 1);
  localparam int ADDR_W = $clog2(MAX_LINES);
  localparam int FW     = ltbl_pkg::FIELD_W;
  localparam int IW     = ltbl_pkg::IDX_W;
  localparam int SUM_W  = (OFFSET_BITS + 2 > FW + 1) ? OFFSET_BITS + 2 : FW + 1;
  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
  localparam logic [SUM_W-1:0]       LWB_SAT = SUM_W'(ltbl_pkg::FIELD_MAX);
  localparam logic [CNT_W-1:0]       CNT_MAX = CNT_W'(MAX_LINES);

  // Text state.
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] cls_r, cls_nxt;
  logic                   crp_r, crp_nxt;
  logic                   fin_r, fin_nxt;
  logic [CNT_W-1:0]       lc_r, lc_nxt;
  logic                   ovf_r, ovf_nxt;

  // Search state.
  logic [CNT_W-1:0]       lo_r, hi_r, mid_r;
  logic [OFFSET_BITS-1:0] qoff_r;

  // Line table: start and end offset of each stored line.
  logic [2*OFFSET_BITS-1:0] mem [MAX_LINES];
  logic [2*OFFSET_BITS-1:0] rdata_r;

  // Result register payload.
  logic          kind_r;
  logic [FW-1:0] start_out_r, len_out_r, lwb_out_r;
  logic [IW-1:0] idx_out_r;
  logic          ovf_out_r, last_r;

  // Effective state after the clear that a byte following end of text causes.
  logic                   fin_clr;
  logic [OFFSET_BITS-1:0] pos_e, cls_e, pos_inc, pos_dec;
  logic                   crp_e, ovf_e;
  logic [CNT_W-1:0]       lc_e;
  logic                   is_cr, is_lf, byte_emits;

  // Line record build.
  logic [OFFSET_BITS-1:0] ln_end, ln_stop, ln_len;
  logic [1:0]             ln_brk;
  logic [SUM_W-1:0]       lwb, lwb_sat;
  logic                   room, line_op, mem_we;
  logic [CNT_W-1:0]       lc_line;
  logic                   ovf_line;
  logic [FW+OFFSET_BITS-1:0] start_ext, len_ext;

  // Search helpers.
  logic [CNT_W:0]            mid_sum;
  logic [CNT_W-1:0]          mid;
  logic [ADDR_W-1:0]         rd_addr;
  logic [OFFSET_BITS-1:0]    rd_start, rd_stop;
  logic [FW+OFFSET_BITS-1:0] qoff_ext;
  logic [IW+CNT_W-1:0]       idx_ext;
  logic                      load_line, load_ans;

  // Position and break decoding.
  always_comb begin
    fin_clr    = (op == ltbl_pkg::OP_BYTE) && fin_r;
    pos_e      = fin_clr ? '0 : pos_r;
    cls_e      = fin_clr ? '0 : cls_r;
    crp_e      = fin_clr ? 1'b0 : crp_r;
    ovf_e      = fin_clr ? 1'b0 : ovf_r;
    lc_e       = fin_clr ? '0 : lc_r;
    pos_inc    = (pos_e == OFF_MAX) ? pos_e : pos_e + 1'b1;
    pos_dec    = (pos_e == '0) ? '0 : pos_e - 1'b1;
    is_cr      = (in_char_byte == ltbl_pkg::CH_CR);
    is_lf      = (in_char_byte == ltbl_pkg::CH_LF);
    byte_emits = crp_e || is_lf;
  end

  // One line record: end and break width depend on the operation.
  always_comb begin
    case (op)
      ltbl_pkg::OP_BYTE: begin
        ln_end = crp_e ? pos_dec : pos_e;
        ln_brk = (crp_e && is_lf) ? 2'd2 : 2'd1;
      end
      ltbl_pkg::OP_FLUSH: begin
        ln_end = pos_dec;
        ln_brk = 2'd1;
      end
      default: begin
        ln_end = pos_e;
        ln_brk = 2'd0;
      end
    endcase
    ln_stop   = (ln_end > cls_e) ? ln_end : cls_e;
    ln_len    = ln_stop - cls_e;
    lwb       = SUM_W'(ln_len) + SUM_W'(ln_brk);
    lwb_sat   = (lwb > LWB_SAT) ? LWB_SAT : lwb;
    room      = lc_e < CNT_MAX;
    line_op   = ((op == ltbl_pkg::OP_BYTE) && byte_emits) ||
                (op == ltbl_pkg::OP_FLUSH) || (op == ltbl_pkg::OP_FINAL);
    mem_we    = line_op && room;
    lc_line   = room ? lc_e + 1'b1 : lc_e;
    ovf_line  = room ? ovf_e : 1'b1;
    start_ext = {{FW{1'b0}}, cls_e};
    len_ext   = {{FW{1'b0}}, ln_len};
  end

  // Next text state.
  always_comb begin
    pos_nxt = pos_r;
    cls_nxt = cls_r;
    crp_nxt = crp_r;
    fin_nxt = fin_r;
    lc_nxt  = lc_r;
    ovf_nxt = ovf_r;
    case (op)
      ltbl_pkg::OP_BYTE: begin
        fin_nxt = 1'b0;
        pos_nxt = pos_inc;
        cls_nxt = is_lf ? pos_inc : (crp_e ? pos_e : cls_e);
        crp_nxt = is_cr;
        lc_nxt  = byte_emits ? lc_line : lc_e;
        ovf_nxt = byte_emits ? ovf_line : ovf_e;
      end
      ltbl_pkg::OP_FLUSH: begin
        cls_nxt = pos_r;
        crp_nxt = 1'b0;
        lc_nxt  = lc_line;
        ovf_nxt = ovf_line;
      end
      ltbl_pkg::OP_FINAL: begin
        fin_nxt = 1'b1;
        lc_nxt  = lc_line;
        ovf_nxt = ovf_line;
      end
      default: fin_nxt = fin_r;
    endcase
  end

  // Search midpoint and table read fields.
  always_comb begin
    mid_sum   = {1'b0, lo_r} + {1'b0, hi_r};
    mid       = mid_sum[CNT_W:1];
    rd_addr   = mid[ADDR_W-1:0];
    rd_start  = rdata_r[2*OFFSET_BITS-1:OFFSET_BITS];
    rd_stop   = rdata_r[OFFSET_BITS-1:0];
    qoff_ext  = {{OFFSET_BITS{1'b0}}, in_query_offset};
    idx_ext   = {{IW{1'b0}}, lo_r};
    load_line = line_op;
    load_ans  = (op == ltbl_pkg::OP_QANS);
  end

  // A pending CR never survives end of text, so registered state and the input
  // byte alone tell whether a byte closes a line.
  assign status.byte_emits    = (crp_r && !fin_r) || (in_char_byte == ltbl_pkg::CH_LF);
  assign status.cr_pending    = crp_r;
  assign status.text_finished = fin_r;
  assign status.search_done   = lo_r >= hi_r;

  // Text state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      cls_r <= '0;
      crp_r <= 1'b0;
      fin_r <= 1'b0;
      lc_r  <= '0;
      ovf_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      cls_r <= cls_nxt;
      crp_r <= crp_nxt;
      fin_r <= fin_nxt;
      lc_r  <= lc_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  // Line table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[lc_e[ADDR_W-1:0]] <= {cls_e, ln_stop};
    end
    if (op == ltbl_pkg::OP_QREAD) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Binary search bounds: a read step, then a compare step that narrows them.
  always_ff @(posedge clk) begin
    case (op)
      ltbl_pkg::OP_QSTART: begin
        lo_r   <= '0;
        hi_r   <= lc_r;
        qoff_r <= qoff_ext[OFFSET_BITS-1:0];
      end
      ltbl_pkg::OP_QREAD: mid_r <= mid;
      ltbl_pkg::OP_QCMP: begin
        if (qoff_r < rd_start) begin
          hi_r <= mid_r;
        end else if (qoff_r >= rd_stop) begin
          lo_r <= mid_r + 1'b1;
        end else begin
          lo_r <= mid_r;
          hi_r <= mid_r;
        end
      end
      default: mid_r <= mid_r;
    endcase
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (load_line) begin
      kind_r      <= ltbl_pkg::KIND_LINE;
      start_out_r <= start_ext[FW-1:0];
      len_out_r   <= len_ext[FW-1:0];
      lwb_out_r   <= lwb_sat[FW-1:0];
      idx_out_r   <= '0;
      ovf_out_r   <= ovf_line;
      last_r      <= (op != ltbl_pkg::OP_FLUSH);
    end else if (load_ans) begin
      kind_r      <= ltbl_pkg::KIND_ANSWER;
      start_out_r <= '0;
      len_out_r   <= '0;
      lwb_out_r   <= '0;
      idx_out_r   <= idx_ext[IW-1:0];
      ovf_out_r   <= ovf_r;
      last_r      <= 1'b1;
    end
  end

  assign out_kind              = kind_r;
  assign out_line_offset       = start_out_r;
  assign out_line_length       = len_out_r;
  assign out_length_with_break = lwb_out_r;
  assign out_line_index        = idx_out_r;
  assign out_overflow          = ovf_out_r;
  assign out_last              = last_r;

endmodule

>>> hdl/line_table_builder_and_lookup.sv
// Top level of the line table builder and offset lookup block.
//
// Input channel (in_valid/in_stall): one command per beat. A text byte splits the
// text into lines (CR LF, lone CR, lone LF); end of text flushes a pending CR line
// and emits the final line; a query returns the number of stored lines whose end
// lies at or below in_query_offset. A byte after end of text starts a new text.
// Result channel (out_valid/out_stall): one beat per line record or query answer,
// out_last marks the final beat an input beat causes.
// Timing and throughput: the record of a text byte appears the cycle after
// acceptance, and bytes stream at one per cycle while no stalled beat holds the
// result register. End of text gives one or two records. A query runs a binary
// search over the table memory, each step a registered read and then a compare,
// and loads its answer when the search ends; no input beat is taken meanwhile.
// Reset clears the positions, flags and line count; the table needs no clearing.
// When the receiver stalls, the result beat holds and no new input beat is taken
// until the result register can be refilled.
module line_table_builder_and_lookup #(
  parameter int MAX_LINES   = 1024,
  parameter int OFFSET_BITS = 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ltbl_pkg::CMD_W-1:0]        in_command,
  input  logic [ltbl_pkg::CHAR_W-1:0]       in_char_byte,
  input  logic [ltbl_pkg::FIELD_W-1:0]      in_query_offset,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_kind,
  output logic [ltbl_pkg::FIELD_W-1:0]      out_line_offset,
  output logic [ltbl_pkg::FIELD_W-1:0]      out_line_length,
  output logic [ltbl_pkg::FIELD_W-1:0]      out_length_with_break,
  output logic [ltbl_pkg::IDX_W-1:0]        out_line_index,
  output logic                              out_overflow,
  output logic                              out_last
);

  ltbl_pkg::status_t status;
  ltbl_pkg::op_t     op;

  // Sequencing and handshake control.
  ltbl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .op         (op)
  );

  // Line tracking, table and search.
  ltbl_dpath #(
    .MAX_LINES   (MAX_LINES),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dpath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .op                    (op),
    .in_char_byte          (in_char_byte),
    .in_query_offset       (in_query_offset),
    .status                (status),
    .out_kind              (out_kind),
    .out_line_offset       (out_line_offset),
    .out_line_length       (out_line_length),
    .out_length_with_break (out_length_with_break),
    .out_line_index        (out_line_index),
    .out_overflow          (out_overflow),
    .out_last              (out_last)
  );

endmodule
